// ===== src/hgcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgcd_pkg
// shared constants, types and helpers of the haversine distance unit
// ----------------------------------------------------------------------------
package hgcd_pkg;

  // input and output number formats
  localparam int ANGLE_FRAC_BITS = 20;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int LON_W           = 29;
  localparam int LAT_W           = 28;
  localparam int RADIUS_W        = 24;
  localparam int DIST_W          = 34;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6378137;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SPHERE_RADIUS = 1'b0;

  // angle lanes into the rotation stage
  localparam int LANES     = 4;
  localparam int LANE_LAT1 = 0;
  localparam int LANE_LAT2 = 1;
  localparam int LANE_DLAT = 2;
  localparam int LANE_DLON = 3;
  localparam int LANE_W    = LON_W + 1;

  // degrees to binary angle: 360 * 2^f = 45 * 2^(f+3)
  localparam int DEG_TURN   = 360;
  localparam int DIV_CONST  = DEG_TURN / 8;
  localparam int DIV_BIAS   = DIV_CONST / 2;
  localparam int LAT_SHIFT  = 32 - ANGLE_FRAC_BITS - 3;
  localparam int DIFF_SHIFT = 31 - ANGLE_FRAC_BITS - 3;
  localparam int DIV_IN_W   = LON_W + LAT_SHIFT;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (DIV_IN_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_W      = DIV_STAGES * DIV_STEP;
  localparam int DIV_REM_W  = 6;
  localparam int BAM_W      = 32;

  // cordic datapath
  localparam int Q_FRAC       = 30;
  localparam int CW           = 34;
  localparam int CORDIC_ITERS = 32;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [31:0]   q30_t;
  localparam cval_t CORDIC_GAIN_INV = 34'sh026DD3B6A;
  localparam cval_t Q_ONE_C         = cval_t'(64'sd1 <<< Q_FRAC);
  localparam cval_t HALF_TURN_C     = cval_t'(64'sd1 <<< (Q_FRAC + 1));

  // square roots
  localparam int SQ_STEPS  = 31;
  localparam int SQ_ROOT_W = 31;
  localparam int SQ_REM_W  = 33;
  localparam int SQ_RAD_W  = 2 * SQ_STEPS;
  localparam int SQ_Y      = 0;
  localparam int SQ_X      = 1;
  localparam int A_W       = Q_FRAC + 1;
  localparam logic [A_W-1:0] A_ONE = A_W'(64'd1 << Q_FRAC);

  // scaling to distance
  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam int          CRAD_W     = 32;
  localparam int          PROD_W     = CRAD_W + RADIUS_W;
  localparam int          DIST_SHIFT = Q_FRAC - DIST_FRAC_BITS;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // arctangent of 2^-i as binary angle, 2^32 per turn
  function automatic cval_t atan_bam(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return cval_t'({2'b00, v});
  endfunction

  // q30 product with round half up
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = a * b + (64'sd1 <<< (Q_FRAC - 1));
    return q30_t'(p >>> Q_FRAC);
  endfunction

endpackage

// ===== src/haversine_great_circle_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_unit
// fully pipelined great-circle distance between two points on a sphere
// ----------------------------------------------------------------------------
// One pair of points is taken on every clock in which start is high; busy is
// tied low, so the unit never refuses a beat. Each pair comes out as a
// single-cycle out_strobe with out_distance, in the order the pairs went
// in. The pipeline sections, in order: a 4-bit-per-stage long division
// that turns degrees into binary angle (10 stages), a 32-stage rotation
// cordic for the cosines and half-angle sines, two multiply stages and a
// clamp, a 31-stage bit-per-stage square root, a 32-stage vectoring cordic
// for atan2, and a few scaling stages at the end. There is no back-pressure
// on the result side, so the receiver must take every strobe. The sphere
// radius is written through the apb port at byte address 0 and should only
// be changed while no pair is in flight.
module haversine_great_circle_distance_unit
  import hgcd_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // input beat
  input  logic                         start,
  output logic                         busy,
  input  logic signed [LON_W-1:0]      in_lon_first,
  input  logic signed [LAT_W-1:0]      in_lat_first,
  input  logic signed [LON_W-1:0]      in_lon_second,
  input  logic signed [LAT_W-1:0]      in_lat_second,
  // result beat
  output logic                         out_strobe,
  output logic [DIST_W-1:0]            out_distance,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_W-1:0]        paddr,
  input  logic [CFG_DATA_W-1:0]        pwdata,
  output logic [CFG_DATA_W-1:0]        prdata,
  output logic                         pready
);

  // pipeline positions, index into the valid chain
  localparam int POS_S0  = 0;
  localparam int POS_S1  = POS_S0 + 1;
  localparam int POS_DIV = POS_S1 + DIV_STAGES;
  localparam int POS_P   = POS_DIV + 1;
  localparam int POS_F   = POS_P + 1;
  localparam int POS_ROT = POS_F + CORDIC_ITERS;
  localparam int POS_O   = POS_ROT + 1;
  localparam int POS_M1  = POS_O + 1;
  localparam int POS_M2  = POS_M1 + 1;
  localparam int POS_A   = POS_M2 + 1;
  localparam int POS_SQ  = POS_A + SQ_STEPS;
  localparam int POS_VEC = POS_SQ + CORDIC_ITERS;
  localparam int POS_Z   = POS_VEC + 1;
  localparam int POS_K1  = POS_Z + 1;
  localparam int POS_K2  = POS_K1 + 1;
  localparam int POS_D   = POS_K2 + 1;
  localparam int LAT     = POS_D + 1;

  logic accept;
  logic [POS_D:0] vld_r;
  logic [RADIUS_W-1:0] radius_r;

  // --------------------------------------------------------------------------
  // control: handshake, valid chain, radius register
  // --------------------------------------------------------------------------
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPHERE_RADIUS) ? CFG_DATA_W'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      radius_r <= RADIUS_RESET;
    end else begin
      vld_r <= {vld_r[POS_D-1:0], accept};
      if (psel && penable && pwrite && pready && paddr[2] == REG_SPHERE_RADIUS) begin
        radius_r <= pwdata[RADIUS_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // entry: the four angles that need a sine or cosine
  // --------------------------------------------------------------------------
  logic signed [LANE_W-1:0] lane_v_r [LANES];

  always_ff @(posedge clk) begin
    lane_v_r[LANE_LAT1] <= LANE_W'(in_lat_first);
    lane_v_r[LANE_LAT2] <= LANE_W'(in_lat_second);
    lane_v_r[LANE_DLAT] <= LANE_W'(in_lat_second) - LANE_W'(in_lat_first);
    lane_v_r[LANE_DLON] <= LANE_W'(in_lon_second) - LANE_W'(in_lon_first);
  end

  // --------------------------------------------------------------------------
  // degrees to binary angle: magnitude scaled, then long division by 45,
  // four quotient bits per stage; the lat lanes get one more bit of scale
  // since the differences are halved, their lanes having two turns per 2^32
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0]     div_y_r   [LANES][DIV_STAGES+1];
  logic [DIV_REM_W-1:0] div_rem_r [LANES][DIV_STAGES+1];
  logic [BAM_W-1:0]     div_q_r   [LANES][DIV_STAGES+1];
  logic                 div_neg_r [LANES][DIV_STAGES+1];
  logic [DIV_W-1:0]     div_y_nxt [LANES];
  logic [DIV_REM_W-1:0] div_rem_nxt [LANES][DIV_STAGES];
  logic [BAM_W-1:0]     div_q_nxt   [LANES][DIV_STAGES];

  always_comb begin
    logic [LANE_W-1:0]    mag;
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_REM_W:0]   trial;
    logic [BAM_W-1:0]     quo;
    for (int l = 0; l < LANES; l++) begin
      mag = lane_v_r[l][LANE_W-1] ? LANE_W'(-lane_v_r[l]) : LANE_W'(lane_v_r[l]);
      if (l == LANE_LAT1 || l == LANE_LAT2) begin
        div_y_nxt[l] = (DIV_W'(mag) << LAT_SHIFT) + DIV_W'(DIV_BIAS);
      end else begin
        div_y_nxt[l] = (DIV_W'(mag) << DIFF_SHIFT) + DIV_W'(DIV_BIAS);
      end
      for (int d = 0; d < DIV_STAGES; d++) begin
        rem = div_rem_r[l][d];
        quo = div_q_r[l][d];
        for (int j = 0; j < DIV_STEP; j++) begin
          trial = {rem, div_y_r[l][d][DIV_W-1-DIV_STEP*d-j]};
          if (trial >= (DIV_REM_W+1)'(DIV_CONST)) begin
            rem = DIV_REM_W'(trial - (DIV_REM_W+1)'(DIV_CONST));
            quo = {quo[BAM_W-2:0], 1'b1};
          end else begin
            rem = trial[DIV_REM_W-1:0];
            quo = {quo[BAM_W-2:0], 1'b0};
          end
        end
        div_rem_nxt[l][d] = rem;
        div_q_nxt[l][d]   = quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      div_y_r[l][0]   <= div_y_nxt[l];
      div_rem_r[l][0] <= '0;
      div_q_r[l][0]   <= '0;
      div_neg_r[l][0] <= lane_v_r[l][LANE_W-1];
      for (int d = 0; d < DIV_STAGES; d++) begin
        div_y_r[l][d+1]   <= div_y_r[l][d];
        div_rem_r[l][d+1] <= div_rem_nxt[l][d];
        div_q_r[l][d+1]   <= div_q_nxt[l][d];
        div_neg_r[l][d+1] <= div_neg_r[l][d];
      end
    end
  end

  // signed binary angle
  logic [BAM_W-1:0] bam_r [LANES];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      bam_r[l] <= div_neg_r[l][DIV_STAGES] ? BAM_W'(-div_q_r[l][DIV_STAGES])
                                           : div_q_r[l][DIV_STAGES];
    end
  end

  // --------------------------------------------------------------------------
  // rotation cordic, one iteration per stage; angles beyond a quarter turn
  // are folded by a half turn and the outputs negated at the end
  // --------------------------------------------------------------------------
  cval_t rx_r [LANES][CORDIC_ITERS+1];
  cval_t ry_r [LANES][CORDIC_ITERS+1];
  cval_t rz_r [LANES][CORDIC_ITERS+1];
  logic  rflip_r [LANES][CORDIC_ITERS+1];
  cval_t rz0_nxt [LANES];
  logic  rflip0_nxt [LANES];
  cval_t rx_nxt [LANES][CORDIC_ITERS];
  cval_t ry_nxt [LANES][CORDIC_ITERS];
  cval_t rz_nxt [LANES][CORDIC_ITERS];

  always_comb begin
    cval_t zs;
    cval_t dx;
    cval_t dy;
    for (int l = 0; l < LANES; l++) begin
      zs = cval_t'($signed(bam_r[l]));
      if (zs > Q_ONE_C || zs < -Q_ONE_C) begin
        rz0_nxt[l]    = (zs > 0) ? zs - HALF_TURN_C : zs + HALF_TURN_C;
        rflip0_nxt[l] = 1'b1;
      end else begin
        rz0_nxt[l]    = zs;
        rflip0_nxt[l] = 1'b0;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        dx = ry_r[l][i] >>> i;
        dy = rx_r[l][i] >>> i;
        if (!rz_r[l][i][CW-1]) begin
          rx_nxt[l][i] = rx_r[l][i] - dx;
          ry_nxt[l][i] = ry_r[l][i] + dy;
          rz_nxt[l][i] = rz_r[l][i] - atan_bam(i);
        end else begin
          rx_nxt[l][i] = rx_r[l][i] + dx;
          ry_nxt[l][i] = ry_r[l][i] - dy;
          rz_nxt[l][i] = rz_r[l][i] + atan_bam(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      rx_r[l][0]    <= CORDIC_GAIN_INV;
      ry_r[l][0]    <= '0;
      rz_r[l][0]    <= rz0_nxt[l];
      rflip_r[l][0] <= rflip0_nxt[l];
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        rx_r[l][i+1]    <= rx_nxt[l][i];
        ry_r[l][i+1]    <= ry_nxt[l][i];
        rz_r[l][i+1]    <= rz_nxt[l][i];
        rflip_r[l][i+1] <= rflip_r[l][i];
      end
    end
  end

  // cosines of the latitudes, sines of the half differences
  q30_t cs_r [LANES];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (l == LANE_LAT1 || l == LANE_LAT2) begin
        cs_r[l] <= rflip_r[l][CORDIC_ITERS] ? q30_t'(-rx_r[l][CORDIC_ITERS])
                                            : q30_t'(rx_r[l][CORDIC_ITERS]);
      end else begin
        cs_r[l] <= rflip_r[l][CORDIC_ITERS] ? q30_t'(-ry_r[l][CORDIC_ITERS])
                                            : q30_t'(ry_r[l][CORDIC_ITERS]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // haversine term a, clamped to [0, 1]
  // --------------------------------------------------------------------------
  q30_t p_slat_r;
  q30_t p_cc_r;
  q30_t p_slon_r;
  q30_t p_slat2_r;
  q30_t p_prod_r;
  logic signed [32:0] a_sum;
  logic [A_W-1:0] a_nxt;

  always_ff @(posedge clk) begin
    p_slat_r  <= mulq(cs_r[LANE_DLAT], cs_r[LANE_DLAT]);
    p_cc_r    <= mulq(cs_r[LANE_LAT1], cs_r[LANE_LAT2]);
    p_slon_r  <= mulq(cs_r[LANE_DLON], cs_r[LANE_DLON]);
    p_slat2_r <= p_slat_r;
    p_prod_r  <= mulq(p_cc_r, p_slon_r);
  end

  always_comb begin
    a_sum = 33'(p_slat2_r) + 33'(p_prod_r);
    if (a_sum[32]) begin
      a_nxt = '0;
    end else if (a_sum > 33'sd1073741824) begin
      a_nxt = A_ONE;
    end else begin
      a_nxt = A_W'(a_sum);
    end
  end

  // --------------------------------------------------------------------------
  // floor square roots of a and 1-a, one root bit per stage
  // --------------------------------------------------------------------------
  logic [A_W-1:0]       sq_val_r  [2][SQ_STEPS+1];
  logic [SQ_ROOT_W-1:0] sq_root_r [2][SQ_STEPS+1];
  logic [SQ_REM_W-1:0]  sq_rem_r  [2][SQ_STEPS+1];
  logic [SQ_ROOT_W-1:0] sq_root_nxt [2][SQ_STEPS];
  logic [SQ_REM_W-1:0]  sq_rem_nxt  [2][SQ_STEPS];

  always_comb begin
    logic [SQ_RAD_W-1:0]   rad;
    logic [SQ_REM_W+1:0]   work;
    logic [SQ_REM_W+1:0]   trial;
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < SQ_STEPS; i++) begin
        rad   = SQ_RAD_W'(sq_val_r[k][i]) << Q_FRAC;
        work  = {sq_rem_r[k][i], rad[2*(SQ_STEPS-1-i)+1 -: 2]};
        trial = (SQ_REM_W+2)'({sq_root_r[k][i], 2'b01});
        if (work >= trial) begin
          sq_rem_nxt[k][i]  = SQ_REM_W'(work - trial);
          sq_root_nxt[k][i] = {sq_root_r[k][i][SQ_ROOT_W-2:0], 1'b1};
        end else begin
          sq_rem_nxt[k][i]  = SQ_REM_W'(work);
          sq_root_nxt[k][i] = {sq_root_r[k][i][SQ_ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_val_r[SQ_Y][0] <= a_nxt;
    sq_val_r[SQ_X][0] <= A_ONE - a_nxt;
    for (int k = 0; k < 2; k++) begin
      sq_root_r[k][0] <= '0;
      sq_rem_r[k][0]  <= '0;
      for (int i = 0; i < SQ_STEPS; i++) begin
        sq_val_r[k][i+1]  <= sq_val_r[k][i];
        sq_root_r[k][i+1] <= sq_root_nxt[k][i];
        sq_rem_r[k][i+1]  <= sq_rem_nxt[k][i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // vectoring cordic: z ends at the binary angle of c/2
  // --------------------------------------------------------------------------
  cval_t vx_r [CORDIC_ITERS];
  cval_t vy_r [CORDIC_ITERS];
  cval_t vz_r [CORDIC_ITERS];
  cval_t vx_nxt [CORDIC_ITERS];
  cval_t vy_nxt [CORDIC_ITERS];
  cval_t vz_nxt [CORDIC_ITERS];

  always_comb begin
    cval_t x;
    cval_t y;
    cval_t z;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (i == 0) begin
        x = cval_t'(sq_root_r[SQ_X][SQ_STEPS]);
        y = cval_t'(sq_root_r[SQ_Y][SQ_STEPS]);
        z = '0;
      end else begin
        x = vx_r[i-1];
        y = vy_r[i-1];
        z = vz_r[i-1];
      end
      if (!y[CW-1]) begin
        vx_nxt[i] = x + (y >>> i);
        vy_nxt[i] = y - (x >>> i);
        vz_nxt[i] = z + atan_bam(i);
      end else begin
        vx_nxt[i] = x - (y >>> i);
        vy_nxt[i] = y + (x >>> i);
        vz_nxt[i] = z - atan_bam(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      vx_r[i] <= vx_nxt[i];
      vy_r[i] <= vy_nxt[i];
      vz_r[i] <= vz_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // clamp angle, to radians, scale by radius, round and saturate
  // --------------------------------------------------------------------------
  logic [A_W-1:0]    zc_r;
  logic [CRAD_W-1:0] crad_r;
  logic [PROD_W-1:0] prod_r;
  logic [DIST_W-1:0] dist_r;
  logic [A_W-1:0]    zc_nxt;
  logic [63:0]       crad_full;
  logic [PROD_W:0]   dist_sum;
  logic [PROD_W-DIST_SHIFT:0] dist_full;

  always_comb begin
    cval_t zf;
    zf = vz_r[CORDIC_ITERS-1];
    if (zf[CW-1]) begin
      zc_nxt = '0;
    end else if (zf > Q_ONE_C) begin
      zc_nxt = A_ONE;
    end else begin
      zc_nxt = A_W'(zf);
    end
    crad_full = 64'(zc_r) * 64'(PI_Q30) + (64'd1 << (Q_FRAC - 1));
    dist_sum  = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(1) << (DIST_SHIFT - 1));
    dist_full = (PROD_W-DIST_SHIFT+1)'(dist_sum >> DIST_SHIFT);
  end

  always_ff @(posedge clk) begin
    zc_r   <= zc_nxt;
    crad_r <= CRAD_W'(crad_full >> Q_FRAC);
    prod_r <= PROD_W'(crad_r) * PROD_W'(radius_r);
    dist_r <= (dist_full > (PROD_W-DIST_SHIFT+1)'(DIST_MAX)) ? DIST_MAX
                                                             : DIST_W'(dist_full);
  end

  assign out_strobe   = vld_r[POS_D];
  assign out_distance = dist_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // every result beat traces back to an accepted pair a fixed latency ago
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT))
    else $error("result beat without a matching input beat");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_strobe)
    else $error("input beat lost in the pipeline");

  // floor roots of a and 1-a: squares sum to at most one, and not far below
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[POS_SQ] |->
      (64'(sq_root_r[SQ_Y][SQ_STEPS]) * 64'(sq_root_r[SQ_Y][SQ_STEPS]) +
       64'(sq_root_r[SQ_X][SQ_STEPS]) * 64'(sq_root_r[SQ_X][SQ_STEPS]))
       <= (64'd1 << (2 * Q_FRAC)))
    else $error("square roots too large");

  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[POS_SQ] |->
      (64'(sq_root_r[SQ_Y][SQ_STEPS]) * 64'(sq_root_r[SQ_Y][SQ_STEPS]) +
       64'(sq_root_r[SQ_X][SQ_STEPS]) * 64'(sq_root_r[SQ_X][SQ_STEPS]) +
       (64'd1 << (Q_FRAC + 3))) > (64'd1 << (2 * Q_FRAC)))
    else $error("square roots too small");

endmodule
